// ===== design/box_window_query_table_top_macros.svh =====
// Assertion macros for the box window query table.
`ifndef BOX_WINDOW_QUERY_TABLE_TOP_MACROS_SVH
`define BOX_WINDOW_QUERY_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BWQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define BWQ_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BWQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BWQ_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

// ===== design/bwq_pkg.sv =====
// Types and constants of the box window query table.
`default_nettype none
package bwq_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [1:0] KIND_INSERT    = 2'd0;
    localparam logic [1:0] KIND_SAME      = 2'd1;
    localparam logic [1:0] KIND_INTERSECT = 2'd2;
    localparam logic [1:0] KIND_CLEAR     = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_CLEARED   = 3'd3;
    localparam logic [2:0] ST_MATCH     = 3'd4;
    localparam logic [2:0] ST_NOMATCH   = 3'd5;

    localparam int TOL_W = 20;
    localparam int RAD_W = 30;
    localparam int OFF_W = 31;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        item_id;
        logic               has_id;
        logic               check_repeat;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic [RAD_W-1:0]   radius;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] match_id;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] low_x;
        logic signed [31:0] low_y;
        logic signed [31:0] high_x;
        logic signed [31:0] high_y;
        logic [31:0]        ident;
        logic               registered;
    } t_entry;

endpackage
`default_nettype wire

// ===== design/bwq_satadd.sv =====
// Shared saturating add/subtract unit: a +/- offset clamped to signed 32 bits.
`default_nettype none
module bwq_satadd
    import bwq_pkg::*;
(
    input  wire logic signed [31:0] i_a,
    input  wire logic [OFF_W-1:0]   i_off,
    input  wire logic               i_sub,
    output logic signed [31:0]      o_sum
);

    logic signed [33:0] ext_a;
    logic signed [33:0] ext_off;
    logic signed [33:0] sum;

    always_comb begin
        ext_a   = {{2{i_a[31]}}, i_a};
        ext_off = {{(34 - OFF_W){1'b0}}, i_off};
        sum     = i_sub ? (ext_a - ext_off) : (ext_a + ext_off);
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
            o_sum = sum[31:0];
        end else if (sum[33]) begin
            o_sum = {1'b1, 31'b0};
        end else begin
            o_sum = {1'b0, {31{1'b1}}};
        end
    end

endmodule
`default_nettype wire

// ===== design/box_window_query_table_top.sv =====
// Top level of the box window query table: sequencer, box memory and result register.
//
//  channel   dir  handshake              payload
//  request   in   i_req_valid/o_req_stall i_req  (t_req)
//  response  out  o_rsp_valid/i_rsp_stall o_rsp  (t_rsp)
//  config    in   i_cfg_we               i_cfg_wdata (tolerance)
//
// An insert whose id is checked first scans the table for a duplicate id.
// A query scans the table too, one entry per cycle unless a stalled response holds it.
// The window and stored box corners go through one saturating adder, one per cycle.
// A stalled response holds the scan when a further match needs the output register.
// Reset empties the table at once; box memory contents are not cleared.
`default_nettype none
`include "box_window_query_table_top_macros.svh"
module box_window_query_table_top
    import bwq_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_stall,
    input  wire t_req             i_req,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_stall,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [TOL_W-1:0] i_cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFF,
        S_WIN,
        S_SCAN,
        S_INS,
        S_EMIT
    } t_state;

    t_state             r_state;
    t_req               r_req;
    logic [TOL_W-1:0]   r_tol;
    logic [OFF_W-1:0]   r_off;
    logic [1:0]         r_step;
    logic signed [31:0] r_win [4];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_rd_vld;
    t_entry             r_rd;
    logic               r_pend_vld;
    logic [31:0]        r_pend_id;
    t_rsp               r_res;
    logic               r_out_vld;
    t_rsp               r_out;
    t_entry             r_mem [TABLE_DEPTH];

    logic signed [31:0] sat_a;
    logic signed [31:0] sat_y;
    logic               out_free;
    logic               is_query;
    logic               y_ok;
    logic               hit_same;
    logic               hit_inter;
    logic               hit;
    logic               dup;
    logic               advance;
    logic               out_load;
    logic               rd_en;
    logic               wr_en;
    t_entry             wr_data;

    always_comb begin
        case (r_step)
            2'd0:    sat_a = r_req.min_x;
            2'd1:    sat_a = r_req.min_y;
            2'd2:    sat_a = r_req.max_x;
            default: sat_a = r_req.max_y;
        endcase
    end

    bwq_satadd u_satadd (
        .i_a   (sat_a),
        .i_off (r_off),
        .i_sub (~r_step[1]),
        .o_sum (sat_y)
    );

    // window: 0 left, 1 down, 2 right, 3 up
    always_comb begin
        out_free  = !r_out_vld || !i_rsp_stall;
        is_query  = (r_req.kind == KIND_SAME) || (r_req.kind == KIND_INTERSECT);
        y_ok      = !(r_rd.high_y < r_win[1] || r_rd.low_y > r_win[3]);
        hit_same  = r_rd.low_x >= r_win[0] && r_rd.low_x <= r_win[2]
                    && r_rd.high_x <= r_win[2] && y_ok;
        hit_inter = r_rd.low_x <= r_win[2] && r_rd.high_x >= r_win[0] && y_ok;
        hit       = (r_req.kind == KIND_SAME) ? hit_same : hit_inter;
        dup       = r_rd.registered && (r_rd.ident == r_req.item_id);
        advance   = !(r_rd_vld && is_query && hit && r_pend_vld && !out_free);
        out_load  = ((r_state == S_SCAN) && r_rd_vld && is_query && hit && r_pend_vld
                     && advance) || ((r_state == S_EMIT) && out_free);
        rd_en     = (r_state == S_SCAN) && advance && (r_idx < r_count);
        wr_en     = (r_state == S_INS) && (r_count < DEPTH_C);
        wr_data.low_x      = r_win[0];
        wr_data.low_y      = r_win[1];
        wr_data.high_x     = r_win[2];
        wr_data.high_y     = r_win[3];
        wr_data.ident      = r_req.item_id;
        wr_data.registered = r_req.has_id && r_req.check_repeat;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tol      <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_step     <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_rsp_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        if (i_req.kind == KIND_CLEAR) begin
                            r_count <= '0;
                            r_res   <= '{status: ST_CLEARED, match_id: '0, last: 1'b1};
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_OFF;
                        end
                    end
                end
                S_OFF: begin
                    if (r_req.kind == KIND_INSERT) begin
                        r_off <= OFF_W'(r_tol);
                    end else begin
                        r_off <= OFF_W'(r_req.radius) + OFF_W'(r_tol);
                    end
                    r_step  <= '0;
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    r_win[r_step] <= sat_y;
                    r_step        <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_idx      <= '0;
                        r_rd_vld   <= 1'b0;
                        r_pend_vld <= 1'b0;
                        if (r_req.kind == KIND_INSERT
                            && !(r_req.has_id && r_req.check_repeat)) begin
                            r_state <= S_INS;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!is_query && r_rd_vld && dup) begin
                        r_rd_vld <= 1'b0;
                        r_res    <= '{status: ST_DUPLICATE, match_id: '0, last: 1'b1};
                        r_state  <= S_EMIT;
                    end else if (!r_rd_vld && r_idx == r_count) begin
                        if (!is_query) begin
                            r_state <= S_INS;
                        end else begin
                            if (r_pend_vld) begin
                                r_res <= '{status: ST_MATCH, match_id: r_pend_id, last: 1'b1};
                            end else begin
                                r_res <= '{status: ST_NOMATCH, match_id: '0, last: 1'b1};
                            end
                            r_state <= S_EMIT;
                        end
                    end else if (advance) begin
                        if (r_rd_vld && is_query && hit) begin
                            if (r_pend_vld) begin
                                r_out <= '{status: ST_MATCH, match_id: r_pend_id,
                                           last: 1'b0};
                            end
                            r_pend_vld <= 1'b1;
                            r_pend_id  <= r_rd.ident;
                        end
                        r_rd_vld <= rd_en;
                        if (rd_en) begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                S_INS: begin
                    if (wr_en) begin
                        r_count <= r_count + CW'(1);
                        r_res   <= '{status: ST_INSERTED, match_id: '0, last: 1'b1};
                    end else begin
                        r_res   <= '{status: ST_FULL, match_id: '0, last: 1'b1};
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out     <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    `BWQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C, "entry count above depth")
    `BWQ_ASSERT(a_idx_bound, i_clk, i_rst_n, r_state == S_SCAN |-> r_idx <= r_count, "scan index past table end")
    `BWQ_ASSERT(a_last_on_final, i_clk, i_rst_n, r_out_vld && r_out.status != ST_MATCH |-> r_out.last, "non-match result without last")
    `BWQ_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> r_count == '0 && !r_out_vld, "reset left table or output busy")

endmodule
`default_nettype wire
